// ===== design/cmtf_pkg.sv =====
package cmtf_pkg;

  localparam int unsigned MemBytes = 262144;
  localparam int unsigned MaxSide  = 1024;
  localparam int unsigned AddrW    = $clog2(MemBytes);

  localparam logic [2:0] RegTexWidth  = 3'd0;
  localparam logic [2:0] RegTexHeight = 3'd1;
  localparam logic [2:0] RegCubeMode  = 3'd2;
  localparam logic [2:0] RegPixFormat = 3'd3;
  localparam logic [2:0] RegTexPres   = 3'd4;

  localparam logic [1:0] FmtRgb8   = 2'd0;
  localparam logic [1:0] FmtRgba8  = 2'd1;
  localparam logic [1:0] FmtRgbF   = 2'd2;
  localparam logic [1:0] FmtRgbaF  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch coordinates, compute major axis
    logic div_start; // begin the two face divisions
    logic index;     // form texel index
    logic offset;    // form byte offset and range check
    logic rd_step;   // read one byte
    logic wr;        // store a byte
    logic done;      // present result
  } cmtf_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic rd_last;
    logic fail;
  } cmtf_sts_t;

  function automatic logic [4:0] bytes_per_texel(input logic [1:0] fmt);
    case (fmt)
      FmtRgb8:  bytes_per_texel = 5'd3;
      FmtRgba8: bytes_per_texel = 5'd4;
      FmtRgbF:  bytes_per_texel = 5'd12;
      default:  bytes_per_texel = 5'd16;
    endcase
  endfunction

endpackage

// ===== design/cmtf_div.sv =====
// restoring divider, one quotient bit per cycle
module cmtf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [43:0] num_i,
  input  logic [32:0] den_i,
  output logic        busy_o,
  output logic [43:0] quo_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [43:0] quo_q, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [34:0] trial;

  assign trial = {rem_q, quo_q[43]} - {2'b00, den_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = 6'd44;
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[34]) begin
        rem_d = trial[33:0];
        quo_d = {quo_q[42:0], 1'b1};
      end else begin
        rem_d = {rem_q[32:0], quo_q[43]};
        quo_d = {quo_q[42:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quo_o  = quo_q;
endmodule

// ===== design/cmtf_datapath.sv =====
module cmtf_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmtf_pkg::cmtf_cmd_t   cmd_i,
  output cmtf_pkg::cmtf_sts_t   sts_o,
  input  logic [10:0]           tex_width_i,
  input  logic [10:0]           tex_height_i,
  input  logic                  cube_mode_i,
  input  logic [1:0]            pixel_format_i,
  input  logic                  texture_present_i,
  input  logic [17:0]           byte_address_i,
  input  logic [7:0]            byte_data_i,
  input  logic signed [31:0]    coord_x_i,
  input  logic signed [31:0]    coord_y_i,
  input  logic signed [31:0]    coord_z_i,
  output logic                  ok_o,
  output logic [31:0]           red_o,
  output logic [31:0]           green_o,
  output logic [31:0]           blue_o,
  output logic [31:0]           alpha_o
);
  logic [7:0] mem_q [cmtf_pkg::MemBytes];
  logic [7:0] rd_data_q;

  logic [15:0] cx_q, cy_q;
  logic [32:0] ax, ay, az;
  logic [1:0]  axis;
  logic signed [32:0] major, umin, vmin;
  logic [32:0] mag_q;
  logic        neg_q;
  logic [1:0]  axis_q;
  logic signed [32:0] u_q, v_q;
  logic        fail_q;

  logic [43:0] xnum, ynum, xquo, yquo;
  logic        xbusy, ybusy;

  logic [10:0] tx_q, ty_q;
  logic [26:0] xp, yp;
  logic [10:0] wx, wy;
  logic [22:0] idx_q;
  logic [26:0] ofs_q;
  logic [4:0]  bpp;
  logic [4:0]  rcnt_q;
  logic [127:0] buf_q;
  logic [2:0]  face;
  logic [21:0] wh;

  assign ax = coord_x_i[31] ? 33'(-34'(coord_x_i)) : {1'b0, coord_x_i};
  assign ay = coord_y_i[31] ? 33'(-34'(coord_y_i)) : {1'b0, coord_y_i};
  assign az = coord_z_i[31] ? 33'(-34'(coord_z_i)) : {1'b0, coord_z_i};

  always_comb begin
    if (ax >= ay && ax >= az) axis = 2'd0;
    else if (ay >= az) axis = 2'd1;
    else axis = 2'd2;
    case (axis)
      2'd0: begin
        major = 33'(coord_x_i); umin = 33'(coord_y_i); vmin = 33'(coord_z_i);
      end
      2'd1: begin
        major = 33'(coord_y_i); umin = 33'(coord_x_i); vmin = 33'(coord_z_i);
      end
      default: begin
        major = 33'(coord_z_i); umin = 33'(coord_x_i); vmin = 33'(coord_y_i);
      end
    endcase
  end

  // (s*u + |M|) * size, with s*u + |M| in [0, 2|M|]
  logic [33:0] su, sv;
  assign su = neg_q ? 34'(mag_q) - 34'(u_q) : 34'(mag_q) + 34'(u_q);
  assign sv = neg_q ? 34'(mag_q) - 34'(v_q) : 34'(mag_q) + 34'(v_q);
  assign xnum = 44'(su) * 44'(tex_width_i);
  assign ynum = 44'(sv) * 44'(tex_height_i);

  cmtf_div u_xdiv (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(xnum),
    .den_i({mag_q[31:0], 1'b0}), .busy_o(xbusy), .quo_o(xquo)
  );
  cmtf_div u_ydiv (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(ynum),
    .den_i({mag_q[31:0], 1'b0}), .busy_o(ybusy), .quo_o(yquo)
  );

  // 2d wrap: floor(c*size/65536) mod size, the integer part of c only adds
  // whole multiples of size, so the fraction bits times size give the index
  assign xp = 27'(cx_q) * 27'(tex_width_i);
  assign yp = 27'(cy_q) * 27'(tex_height_i);
  assign wx = xp[26:16];
  assign wy = yp[26:16];
  assign face = {axis_q, neg_q};
  assign wh = 22'(tex_width_i) * 22'(tex_height_i);
  assign bpp = cmtf_pkg::bytes_per_texel(pixel_format_i);

  logic [10:0] cxi, cyi;
  assign cxi = (xquo > 44'(tex_width_i - 11'd1))  ? tex_width_i - 11'd1  : xquo[10:0];
  assign cyi = (yquo > 44'(tex_height_i - 11'd1)) ? tex_height_i - 11'd1 : yquo[10:0];

  logic [26:0] ofs_d;
  logic [24:0] cube_idx;
  assign cube_idx = 25'(wh) * 25'(face) + 25'(tex_width_i) * 25'(ty_q) + 25'(tx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q <= 1'b0;
      rcnt_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        fail_q <= !texture_present_i || tex_width_i == 11'd0 || tex_height_i == 11'd0
                  || tex_width_i > 11'(cmtf_pkg::MaxSide)
                  || tex_height_i > 11'(cmtf_pkg::MaxSide)
                  || (cube_mode_i && major == 33'd0);
        rcnt_q <= '0;
      end else if (cmd_i.offset) begin
        if (28'(ofs_d) + 28'(bpp) > 28'(cmtf_pkg::MemBytes)) fail_q <= 1'b1;
      end
      if (cmd_i.rd_step) rcnt_q <= rcnt_q + 5'd1;
    end
  end

  assign ofs_d = 27'(idx_q) * 27'(bpp);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cx_q   <= coord_x_i[15:0];
      cy_q   <= coord_y_i[15:0];
      axis_q <= axis;
      neg_q  <= major[32];
      mag_q  <= major[32] ? 33'(-major) : major;
      u_q    <= umin;
      v_q    <= vmin;
    end
    if (cmd_i.index) begin
      tx_q  <= cxi;
      ty_q  <= cyi;
    end
    if (cmd_i.offset) ofs_q <= ofs_d;
    if (cmd_i.rd_step) buf_q <= {rd_data_q, buf_q[127:8]};
  end

  // idx_q loads, 2d or cube form, in the cycle after index latches the quotients
  logic idx_phase_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_phase_q <= 1'b0;
    else idx_phase_q <= cmd_i.index;
  end
  always_ff @(posedge clk_i) begin
    if (idx_phase_q) idx_q <= cube_mode_i ? 23'(cube_idx)
                                          : 23'(wx) + 23'(wy) * 23'(tex_width_i);
  end

  // byte memory, registered read
  logic [26:0] rd_addr;
  assign rd_addr = ofs_q + 27'(rcnt_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem_q[byte_address_i] <= byte_data_i;
    rd_data_q <= mem_q[rd_addr[cmtf_pkg::AddrW-1:0]];
  end

  // reads run ahead of the shift; rd_step drives count, data lags
  assign sts_o.div_busy = xbusy || ybusy;
  assign sts_o.rd_last  = (rcnt_q == bpp);
  assign sts_o.fail     = fail_q;

  // first shifted byte is stale, texel bytes sit in the top bpp bytes
  logic [127:0] aligned;
  assign aligned = buf_q >> (8 * (5'd16 - bpp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_o <= 1'b0;
    end else if (cmd_i.done) begin
      ok_o <= !fail_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      if (fail_q) begin
        red_o <= '0; green_o <= '0; blue_o <= '0; alpha_o <= '0;
      end else if (!pixel_format_i[1]) begin
        red_o   <= {24'd0, aligned[7:0]};
        green_o <= {24'd0, aligned[15:8]};
        blue_o  <= {24'd0, aligned[23:16]};
        alpha_o <= pixel_format_i == cmtf_pkg::FmtRgba8 ? {24'd0, aligned[31:24]} : 32'd255;
      end else begin
        red_o   <= aligned[31:0];
        green_o <= aligned[63:32];
        blue_o  <= aligned[95:64];
        alpha_o <= pixel_format_i == cmtf_pkg::FmtRgbaF ? aligned[127:96] : 32'h3F800000;
      end
    end
  end
endmodule

// ===== design/cmtf_ctrl.sv =====
module cmtf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                cmd_i,
  input  logic                cube_mode_i,
  input  logic [17:0]         byte_address_i,
  input  cmtf_pkg::cmtf_sts_t sts_i,
  output cmtf_pkg::cmtf_cmd_t cmd_o,
  output logic                busy_o,
  output logic                strobe_o
);
  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StDiv   = 8'b0000_0010,
    StIndex = 8'b0000_0100,
    StIdx2  = 8'b0000_1000,
    StOfs   = 8'b0001_0000,
    StRead  = 8'b0010_0000,
    StDone  = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   go;
  assign go = start_i && state_q == StIdle;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (go && cmd_i) begin
          cmd_o.capture = 1'b1;
          state_d = cube_mode_i ? StDiv : StIndex;
        end else if (go) begin
          cmd_o.wr = (32'(byte_address_i) < cmtf_pkg::MemBytes);
        end
      end
      StDiv: begin
        cmd_o.div_start = 1'b1;
        state_d = StIndex;
      end
      StIndex: begin
        if (!sts_i.div_busy) begin
          cmd_o.index = 1'b1;
          state_d = StIdx2;
        end
      end
      StIdx2: state_d = StOfs;
      StOfs: begin
        cmd_o.offset = 1'b1;
        state_d = StRead;
      end
      StRead: begin
        if (sts_i.fail) state_d = StDone;
        else begin
          cmd_o.rd_step = 1'b1;
          if (sts_i.rd_last) state_d = StDone;
        end
      end
      StDone: begin
        cmd_o.done = 1'b1;
        state_d = StOut;
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  assign busy_o   = state_q != StIdle;
  assign strobe_o = state_q == StOut;
endmodule

// ===== design/cube_map_texel_fetch.sv =====
// cube map texel fetch: byte texture store plus nearest-texel lookup
// channels: command in (start/busy), result out (valid_o strobe, one
// cycle, no back-pressure), config write (cfg_valid_i/cfg_ready_o)
// a command is taken when start is high and busy low
// cmd_i=0 stores byte_data_i at byte_address_i, no result
// cmd_i=1 runs a lookup and gives exactly one item on valid_o
// 2d lookup steps: capture, index, index load, offset, the byte reads
// (bpp = 3, 4, 12 or 16 bytes plus one for the registered read), done,
// then the strobe; next command can be taken in the cycle after the strobe
// cube lookup adds the two face divisions, which run in parallel one
// quotient bit per cycle; the divider sets the cube rate
// texel bytes come one per cycle from the byte memory's read port
// failed lookups skip the reads and return ok=0 with zero channels
// reset: registers to defaults (1x1, 2d, rgba8, no texture); memory is
// not cleared and reads of unwritten bytes return anything
// config writes are always ready and must be done while idle
module cube_map_texel_fetch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [17:0]        byte_address_i,
  input  logic [7:0]         byte_data_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  output logic               valid_o,
  output logic               ok_o,
  output logic [31:0]        red_o,
  output logic [31:0]        green_o,
  output logic [31:0]        blue_o,
  output logic [31:0]        alpha_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  cmtf_pkg::cmtf_cmd_t cmd;
  cmtf_pkg::cmtf_sts_t sts;

  // configuration registers
  logic [10:0] tex_width_q, tex_height_q;
  logic        cube_mode_q, texture_present_q;
  logic [1:0]  pixel_format_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q       <= 11'd1;
      tex_height_q      <= 11'd1;
      cube_mode_q       <= 1'b0;
      pixel_format_q    <= cmtf_pkg::FmtRgba8;
      texture_present_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cmtf_pkg::RegTexWidth:  tex_width_q       <= cfg_data_i[10:0];
        cmtf_pkg::RegTexHeight: tex_height_q      <= cfg_data_i[10:0];
        cmtf_pkg::RegCubeMode:  cube_mode_q       <= cfg_data_i[0];
        cmtf_pkg::RegPixFormat: pixel_format_q    <= cfg_data_i[1:0];
        cmtf_pkg::RegTexPres:   texture_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cmtf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .cmd_i, .cube_mode_i(cube_mode_q),
    .byte_address_i, .sts_i(sts), .cmd_o(cmd), .busy_o(busy), .strobe_o(valid_o)
  );

  cmtf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .tex_width_i(tex_width_q), .tex_height_i(tex_height_q),
    .cube_mode_i(cube_mode_q), .pixel_format_i(pixel_format_q),
    .texture_present_i(texture_present_q),
    .byte_address_i, .byte_data_i, .coord_x_i, .coord_y_i, .coord_z_i,
    .ok_o, .red_o, .green_o, .blue_o, .alpha_o
  );

  // a result never appears while a command could be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> busy)
    else $error("result while idle");
  // a failed lookup reports zero red and alpha channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ok_o |-> red_o == 32'd0 && alpha_o == 32'd0)
    else $error("failed lookup with data");
  // an accepted lookup makes the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i |=> busy)
    else $error("lookup dropped");
endmodule

// ===== verif/cmtf_checker.sv =====
`timescale 1ns / 1ps

module cmtf_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic               cmd_i,
  input  logic [17:0]        byte_address_i,
  input  logic [7:0]         byte_data_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic               valid_o,
  input  logic               ok_o,
  input  logic [31:0]        red_o,
  input  logic [31:0]        green_o,
  input  logic [31:0]        blue_o,
  input  logic [31:0]        alpha_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic        ok;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
  } texel_t;

  logic [7:0]  tex_mem [cmtf_pkg::MemBytes];
  logic [10:0] width_q, height_q;
  logic        cube_q, present_q;
  logic [1:0]  fmt_q;
  texel_t      texel_q [$];

  assign pending = texel_q.size();

  // repeat addressing: floor(c * size / 2^16) mod size
  function automatic longint wrap_coord(longint c, longint size);
    longint r;
    r = ((c * size) >>> 16) % size;
    if (r < 0) r += size;
    return r;
  endfunction

  function automatic longint face_coord(longint u, longint major, longint size);
    longint mag, su, idx;
    mag = major < 0 ? -major : major;
    su  = major < 0 ? -u : u;
    idx = ((su + mag) * size) / (2 * mag);
    if (idx > size - 1) idx = size - 1;
    return idx;
  endfunction

  function automatic logic [31:0] mem_word(longint ofs);
    return {tex_mem[ofs+3], tex_mem[ofs+2], tex_mem[ofs+1], tex_mem[ofs]};
  endfunction

  function automatic texel_t fetch_texel(longint x, longint y, longint z);
    texel_t t;
    longint w, h, idx, ofs, bpt, d[3], a[3], fx, fy;
    int axis, face;
    t = '0;
    w = width_q;
    h = height_q;
    if (!present_q || w == 0 || h == 0 || w > cmtf_pkg::MaxSide || h > cmtf_pkg::MaxSide)
      return t;
    if (!cube_q) begin
      idx = wrap_coord(x, w) + wrap_coord(y, h) * w;
    end else begin
      d[0] = x; d[1] = y; d[2] = z;
      for (int k = 0; k < 3; k++) a[k] = d[k] < 0 ? -d[k] : d[k];
      if (a[0] >= a[1] && a[0] >= a[2]) axis = 0;
      else if (a[1] >= a[2]) axis = 1;
      else axis = 2;
      if (d[axis] == 0) return t;  // zero vector
      face = 2 * axis + (d[axis] < 0 ? 1 : 0);
      fx = face_coord(d[axis != 0 ? 0 : 1], d[axis], w);
      fy = face_coord(d[axis < 2 ? 2 : 1], d[axis], h);
      idx = w * h * face + w * fy + fx;
    end
    case (fmt_q)
      cmtf_pkg::FmtRgb8:  bpt = 3;
      cmtf_pkg::FmtRgba8: bpt = 4;
      cmtf_pkg::FmtRgbF:  bpt = 12;
      default:            bpt = 16;
    endcase
    ofs = idx * bpt;
    if (ofs + bpt > cmtf_pkg::MemBytes) return t;
    t.ok = 1'b1;
    if (fmt_q == cmtf_pkg::FmtRgb8 || fmt_q == cmtf_pkg::FmtRgba8) begin
      t.red   = tex_mem[ofs];
      t.green = tex_mem[ofs+1];
      t.blue  = tex_mem[ofs+2];
      t.alpha = fmt_q == cmtf_pkg::FmtRgba8 ? 32'(tex_mem[ofs+3]) : 32'd255;
    end else begin
      t.red   = mem_word(ofs);
      t.green = mem_word(ofs + 4);
      t.blue  = mem_word(ofs + 8);
      t.alpha = fmt_q == cmtf_pkg::FmtRgbaF ? mem_word(ofs + 12) : 32'h3F80_0000;
    end
    return t;
  endfunction

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    texel_t e;
    if (!rst_ni) begin
      width_q   <= 11'd1;
      height_q  <= 11'd1;
      cube_q    <= 1'b0;
      fmt_q     <= cmtf_pkg::FmtRgba8;
      present_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cmtf_pkg::RegTexWidth:  width_q   <= cfg_data_i[10:0];
          cmtf_pkg::RegTexHeight: height_q  <= cfg_data_i[10:0];
          cmtf_pkg::RegCubeMode:  cube_q    <= cfg_data_i[0];
          cmtf_pkg::RegPixFormat: fmt_q     <= cfg_data_i[1:0];
          cmtf_pkg::RegTexPres:   present_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (!cmd_i) tex_mem[byte_address_i] = byte_data_i;
        else texel_q.push_back(fetch_texel(coord_x_i, coord_y_i, coord_z_i));
      end
      if (valid_o) begin
        if (texel_q.size() == 0) begin
          $display("%0t: unexpected result exp none act ok=%0b", $time, ok_o);
          fail_count <= fail_count + 1;
        end else begin
          e = texel_q.pop_front();
          if (e !== {ok_o, red_o, green_o, blue_o, alpha_o}) begin
            $display("%0t: texel mismatch exp ok=%0b %h %h %h %h act ok=%0b %h %h %h %h",
                     $time, e.ok, e.red, e.green, e.blue, e.alpha,
                     ok_o, red_o, green_o, blue_o, alpha_o);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_cube_map_texel_fetch.sv =====
`timescale 1ns / 1ps

module tb_cube_map_texel_fetch;

  // longest quiet stretch is a drain plus the settle time
  localparam int StallLimit = 20000;
  localparam int SettleCycles = 120;
  localparam int ItemTarget = 1500;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cmd_i = 1'b0;
  logic [17:0]        byte_address_i = '0;
  logic [7:0]         byte_data_i = '0;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic               valid_o, ok_o, cfg_ready_o;
  logic [31:0]        red_o, green_o, blue_o, alpha_o;
  logic               cfg_valid_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  int                 fail_count, pending;
  int                 stall_cnt = 0;
  bit                 gaps_on = 1'b0;
  int                 items_sent = 0;

  // texture as last programmed, and which store bytes hold data
  longint             cur_w = 1;
  longint             cur_h = 1;
  bit                 cur_cube = 1'b0;
  logic [1:0]         cur_fmt = cmtf_pkg::FmtRgba8;
  bit                 cur_present = 1'b0;
  bit                 written [cmtf_pkg::MemBytes];

  cube_map_texel_fetch dut (.*);
  cmtf_checker u_checker (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: any handshake or result resets the stall count
  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || valid_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // mostly back to back, sometimes a short hole, rarely a long one
  task automatic idle_gap();
    int n;
    n = 0;
    if (gaps_on) begin
      case ($urandom_range(9))
        0, 1, 2: n = $urandom_range(3, 1);
        3:       n = $urandom_range(40, 5);
        default: n = 0;
      endcase
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_item(logic c, logic [17:0] addr, logic [7:0] data,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    start          <= 1'b1;
    cmd_i          <= c;
    byte_address_i <= addr;
    byte_data_i    <= data;
    coord_x_i      <= x;
    coord_y_i      <= y;
    coord_z_i      <= z;
    do @(posedge clk_i); while (busy);
    if (!c) written[addr] = 1'b1;
    items_sent = items_sent + 1;
    idle_gap();
  endtask

  function automatic longint face_pos(longint u, longint major, longint size);
    longint mag, su, idx;
    mag = major < 0 ? -major : major;
    su  = major < 0 ? -u : u;
    idx = ((su + mag) * size) / (2 * mag);
    if (idx > size - 1) idx = size - 1;
    return idx;
  endfunction

  // bytes a lookup reads under the current texture, n = 0 when it fails
  function automatic void lookup_span(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, output longint ofs,
                                      output int n);
    longint w, h, idx, bpt, d[3], a[3];
    int axis;
    ofs = 0;
    n = 0;
    w = cur_w;
    h = cur_h;
    if (!cur_present || w == 0 || h == 0 || w > cmtf_pkg::MaxSide || h > cmtf_pkg::MaxSide)
      return;
    d[0] = longint'($signed(x));
    d[1] = longint'($signed(y));
    d[2] = longint'($signed(z));
    if (!cur_cube) begin
      // repeat wrap depends on the fraction bits only
      idx = ((longint'(x[15:0]) * w) >>> 16) + ((longint'(y[15:0]) * h) >>> 16) * w;
    end else begin
      for (int k = 0; k < 3; k++) a[k] = d[k] < 0 ? -d[k] : d[k];
      if (a[0] >= a[1] && a[0] >= a[2]) axis = 0;
      else if (a[1] >= a[2]) axis = 1;
      else axis = 2;
      if (d[axis] == 0) return;
      idx = w * h * (2 * axis + (d[axis] < 0 ? 1 : 0))
            + w * face_pos(d[axis < 2 ? 2 : 1], d[axis], h)
            + face_pos(d[axis != 0 ? 0 : 1], d[axis], w);
    end
    case (cur_fmt)
      cmtf_pkg::FmtRgb8:  bpt = 3;
      cmtf_pkg::FmtRgba8: bpt = 4;
      cmtf_pkg::FmtRgbF:  bpt = 12;
      default:            bpt = 16;
    endcase
    ofs = idx * bpt;
    if (ofs + bpt > cmtf_pkg::MemBytes) return;
    n = int'(bpt);
  endfunction

  // the bytes of the addressed texel are written first when still empty
  task automatic lookup(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    longint ofs;
    int n;
    lookup_span(x, y, z, ofs, n);
    for (int k = 0; k < n; k++) begin
      if (!written[ofs + k]) send_item(1'b0, 18'(ofs + k), 8'($urandom), 0, 0, 0);
    end
    send_item(1'b1, 18'($urandom), 8'($urandom), x, y, z);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // registers change only with the block idle: drain, then let writes settle
  task automatic set_texture(int w, int h, bit cube, logic [1:0] fmt, bit present);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(cmtf_pkg::RegTexWidth, w);
    write_reg(cmtf_pkg::RegTexHeight, h);
    write_reg(cmtf_pkg::RegCubeMode, cube);
    write_reg(cmtf_pkg::RegPixFormat, fmt);
    write_reg(cmtf_pkg::RegTexPres, present);
    cur_w       = w & 32'h7FF;
    cur_h       = h & 32'h7FF;
    cur_cube    = cube;
    cur_fmt     = fmt;
    cur_present = present;
  endtask

  // full range, small texel-scale values, or exact landmarks
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'h8000_0000 | $urandom_range(3);
      2:       return 32'h7FFF_FFFF - $urandom_range(3);
      3:       return $urandom_range(15) << 16;
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic int rand_side();
    case ($urandom_range(5))
      0:       return 1;
      1:       return cmtf_pkg::MaxSide;
      2:       return $urandom_range(64, 1);
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  initial begin
    int w, h;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no texture after reset
    lookup(32'h0001_0000, 0, 0);

    // single texel, coordinate extremes wrap to it
    set_texture(1, 1, 1'b0, cmtf_pkg::FmtRgb8, 1'b1);
    lookup(32'h7FFF_FFFF, 32'h8000_0000, 0);
    lookup(32'hFFFF_FFFF, 32'h0000_0000, 0);

    // largest 2d texture, most offsets fall outside memory
    set_texture(cmtf_pkg::MaxSide, cmtf_pkg::MaxSide, 1'b0, cmtf_pkg::FmtRgbaF, 1'b1);
    lookup(32'h0000_8000, 32'h0000_0000, 0);
    lookup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    lookup(32'h8000_0000, 32'h0000_0100, 0);

    // non-square cube, each face, zero vector, ties and extremes
    set_texture(4, 3, 1'b1, cmtf_pkg::FmtRgbF, 1'b1);
    lookup(0, 0, 0);
    lookup(32'h0001_0000, 32'h0000_4000, 32'hFFFF_C000);
    lookup(32'hFFFF_0000, 32'h0000_4000, 32'h0000_4000);
    lookup(32'h0000_1000, 32'h0002_0000, 32'h0000_1000);
    lookup(32'h0000_1000, 32'hFFFE_0000, 32'h0000_1000);
    lookup(32'h0000_1000, 32'h0000_1000, 32'h0003_0000);
    lookup(32'h0000_1000, 32'h0000_1000, 32'hFFFD_0000);
    lookup(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    lookup(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

    // bad sizes
    set_texture(0, 5, 1'b0, cmtf_pkg::FmtRgba8, 1'b1);
    lookup(0, 0, 0);
    set_texture(2047, cmtf_pkg::MaxSide + 1, 1'b1, cmtf_pkg::FmtRgba8, 1'b1);
    lookup(32'h0001_0000, 0, 0);

    // large cube, only part of the first face fits in memory
    set_texture(cmtf_pkg::MaxSide, cmtf_pkg::MaxSide, 1'b1, cmtf_pkg::FmtRgba8, 1'b1);
    lookup(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    lookup(32'hFFFF_0000, 0, 0);

    // random phases, every other one without gaps
    for (int ph = 0; items_sent < ItemTarget; ph++) begin
      w = rand_side();
      h = rand_side();
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(1) ? 0 : $urandom_range(2047, cmtf_pkg::MaxSide + 1);
      end
      set_texture(w, h, $urandom_range(1), $urandom_range(3), $urandom_range(7) != 0);
      gaps_on = ph[0];
      for (int i = 0; i < 60 && items_sent < ItemTarget; i++) begin
        if ($urandom_range(3) == 0) send_item(1'b0, 18'($urandom), 8'($urandom), 0, 0, 0);
        else lookup(rand_coord(), rand_coord(), rand_coord());
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
